// ===== hw/rtl/ipimbx_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and request decode type of the ipi mailbox controller
package ipimbx_pkg;

  // fixed mailbox geometry: eight 32-bit words per core, two banks of four
  localparam int MailboxDwords = 4;
  localparam int WordsPerCore  = 2 * MailboxDwords;
  localparam int BankRowsCore  = MailboxDwords;
  localparam int RowSelW       = $clog2(BankRowsCore);

  // request field widths
  localparam int CoreFieldW = 4;
  localparam int OfsW       = 8;
  localparam int SizeW      = 4;
  localparam int DataW      = 64;
  localparam int WordW      = 32;
  localparam int IrqW       = 16;
  localparam int TgtW       = 10;

  // access kinds
  localparam logic FuncRead  = 1'b0;
  localparam logic FuncWrite = 1'b1;

  // legal access sizes
  localparam logic [SizeW-1:0] Size4 = 4'd4;
  localparam logic [SizeW-1:0] Size8 = 4'd8;

  // window register map
  localparam logic [OfsW-1:0] OfsStatus   = 8'h00;
  localparam logic [OfsW-1:0] OfsEnable   = 8'h04;
  localparam logic [OfsW-1:0] OfsSet      = 8'h08;
  localparam logic [OfsW-1:0] OfsClear    = 8'h0c;
  localparam logic [OfsW-1:0] OfsMboxLo   = 8'h20;
  localparam logic [OfsW-1:0] OfsMboxHi   = 8'h3c;
  localparam logic [OfsW-1:0] OfsIpiSend  = 8'h40;
  localparam logic [OfsW-1:0] OfsMailSend = 8'h48;

  // decoded request, one action bit at most besides the read selects
  typedef struct packed {
    logic err;
    logic wide;
    logic mbox_rd;
    logic mbox_wr;
    logic st_rd;
    logic en_rd;
    logic en_wr;
    logic clr_wr;
    logic ipi_wr;
    logic mail_wr;
  } ipimbx_op_t;

endpackage

// ===== hw/rtl/ipimbx_decode.sv =====
`timescale 1ns / 1ps
// request decode and access error checks of the ipi mailbox controller
module ipimbx_decode import ipimbx_pkg::*; #(
  parameter int NUM_CORES = 4
) (
  input  logic                  func_i,
  input  logic [CoreFieldW-1:0] window_core_i,
  input  logic [OfsW-1:0]       offset_i,
  input  logic [SizeW-1:0]      access_size_i,
  input  logic [TgtW-1:0]       target_i,
  output ipimbx_op_t            op_o
);

  logic size_ok, wide, core_ok, tgt_ok, in_mbox, misalign, wr, base_ok;

  always_comb begin
    wr       = (func_i == FuncWrite);
    wide     = (access_size_i == Size8);
    size_ok  = (access_size_i == Size4) || wide;
    core_ok  = ({1'b0, window_core_i} < 5'(NUM_CORES));
    tgt_ok   = ({1'b0, target_i} < 11'(NUM_CORES));
    in_mbox  = (offset_i >= OfsMboxLo) && (offset_i <= OfsMboxHi);
    misalign = wide ? (offset_i[2:0] != 3'd0) : (offset_i[1:0] != 2'd0);
    base_ok  = size_ok && core_ok;

    op_o         = '0;
    op_o.wide    = wide;
    if (!base_ok) begin
      op_o.err = 1'b1;
    end else if (in_mbox) begin
      op_o.err     = misalign;
      op_o.mbox_wr = !misalign && wr;
      op_o.mbox_rd = !misalign && !wr;
    end else if (!wr) begin
      op_o.st_rd = (offset_i == OfsStatus);
      op_o.en_rd = (offset_i == OfsEnable);
    end else begin
      case (offset_i)
        OfsStatus, OfsSet: op_o.err = 1'b1;
        OfsEnable:         op_o.en_wr = 1'b1;
        OfsClear:          op_o.clr_wr = 1'b1;
        OfsIpiSend: begin
          op_o.err    = !tgt_ok;
          op_o.ipi_wr = tgt_ok;
        end
        OfsMailSend: begin
          op_o.err     = !tgt_ok;
          op_o.mail_wr = tgt_ok;
        end
        default: op_o.err = 1'b0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ipi_mailbox_controller_unit.sv =====
`timescale 1ns / 1ps
// top level of the ipi mailbox controller: request register, state, mailbox banks
//
// Inter-processor interrupt and mailbox block for NUM_CORES cores. Each request
// is one bus read or write into a core's 256-byte window: status (0x00),
// enable (0x04), set (0x08, always refused on write), clear (0x0c, write one
// to clear), mailbox words at 0x20..0x3c with 4- or 8-byte little-endian
// accesses, ipi send (0x40) and mail send (0x48) addressed by data[25:16].
// Every request gives exactly one result carrying the read data, the
// per-core interrupt lines after the request, and an access error flag.
// Throughput is one request per clock while the result side does not stall;
// a taken request moves from the request register into the result register
// on its way out. The two mailbox banks, even and odd words, each
// have one write and one read port, so an 8-byte access touches both in the
// same cycle; their read is launched as the request is taken and writes of
// the request ahead are forwarded. Mailbox valid bits give the zero reset
// value, so no clearing pass is needed after reset.
module ipi_mailbox_controller_unit import ipimbx_pkg::*; #(
  parameter int NUM_CORES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // window_core[3:0], offset[11:4], access_size[15:12], write_data[79:16]
  input  logic [79:0] s_axis_tdata_i,
  // func[0]
  input  logic [0:0]  s_axis_tuser_i,
  // result out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[63:0], irq_lines[79:64]
  output logic [79:0] m_axis_tdata_o,
  // access_error[0]
  output logic [0:0]  m_axis_tuser_o
);

  // core index and bank row widths
  localparam int CoreAW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int RowAW    = CoreAW + RowSelW;
  localparam int BankRows = 1 << RowAW;

  // request register
  logic                  req_valid_q;
  logic                  func_q;
  logic [CoreFieldW-1:0] core_q;
  logic [OfsW-1:0]       ofs_q;
  logic [SizeW-1:0]      size_q;
  logic [DataW-1:0]      data_q;

  // result register
  logic             out_valid_q;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic [IrqW-1:0]  irq_q, irq_d;
  logic             err_q;

  // architectural state
  logic [WordW-1:0] status_q [NUM_CORES];
  logic [WordW-1:0] status_d [NUM_CORES];
  logic [WordW-1:0] enable_q [NUM_CORES];

  // mailbox banks: even words in bank 0, odd words in bank 1
  logic [WordW-1:0] bank0_mem [BankRows];
  logic [WordW-1:0] bank1_mem [BankRows];
  logic [BankRows-1:0] bank0_vld_q, bank1_vld_q;

  // registered bank reads with forwarding info
  logic [WordW-1:0] b0_rd_q, b1_rd_q, b0_fwd_q, b1_fwd_q;
  logic             b0_vld_q, b1_vld_q, b0_hit_q, b1_hit_q;

  logic s_acc, adv_out, fire;
  logic [RowAW-1:0] rd_row;

  // bank write ports
  logic             we0, we1;
  logic [RowAW-1:0] wrow0, wrow1;
  logic [WordW-1:0] wdat0, wdat1;

  ipimbx_op_t op;

  logic [DataW-1:0] data_eff;
  logic [WordW-1:0] lo_w, hi_w, word0, word1;
  logic [CoreAW-1:0] core_idx, tgt_idx;
  logic [RowAW-1:0]  win_row, mail_row;

  // handshake: the result register frees as it is taken, the request
  // register frees as its request moves into the result register
  assign adv_out         = !out_valid_q || m_axis_tready_i;
  assign fire            = req_valid_q && adv_out;
  assign s_axis_tready_o = !req_valid_q || adv_out;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // row read for the incoming request: core and word pair in the window
  assign rd_row = {s_axis_tdata_i[CoreAW-1:0], s_axis_tdata_i[8:7]};

  ipimbx_decode #(
    .NUM_CORES(NUM_CORES)
  ) u_decode (
    .func_i       (func_q),
    .window_core_i(core_q),
    .offset_i     (ofs_q),
    .access_size_i(size_q),
    .target_i     (data_q[25:16]),
    .op_o         (op)
  );

  always_comb begin
    // a narrow write carries only the low half
    data_eff = op.wide ? data_q : {{WordW{1'b0}}, data_q[WordW-1:0]};
    lo_w     = data_eff[WordW-1:0];
    hi_w     = data_eff[DataW-1:WordW];
    core_idx = core_q[CoreAW-1:0];
    tgt_idx  = data_q[16 +: CoreAW];
    win_row  = {core_idx, ofs_q[4:3]};
    mail_row = {tgt_idx, data_q[4:3]};
  end

  // mailbox write steering
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    wrow0 = win_row;
    wrow1 = win_row;
    wdat0 = lo_w;
    wdat1 = lo_w;
    if (fire && op.mbox_wr) begin
      if (op.wide) begin
        we0   = 1'b1;
        we1   = 1'b1;
        wdat1 = hi_w;
      end else begin
        we0 = !ofs_q[2];
        we1 = ofs_q[2];
      end
    end else if (fire && op.mail_wr) begin
      wrow0 = mail_row;
      wrow1 = mail_row;
      wdat0 = hi_w;
      wdat1 = hi_w;
      we0   = !data_q[2];
      we1   = data_q[2];
    end
  end

  // next status per core and interrupt lines after the request
  always_comb begin
    irq_d = '0;
    for (int c = 0; c < NUM_CORES; c++) begin
      status_d[c] = status_q[c];
      if (fire && op.clr_wr && core_idx == CoreAW'(c)) begin
        status_d[c] = status_q[c] & ~lo_w;
      end
      if (fire && op.ipi_wr && tgt_idx == CoreAW'(c)) begin
        status_d[c] = status_q[c] | (WordW'(1) << data_q[4:0]);
      end
      irq_d[c] = |status_d[c];
    end
  end

  // read data: forwarded write wins, an unwritten word reads as zero
  always_comb begin
    word0 = b0_hit_q ? b0_fwd_q : (b0_vld_q ? b0_rd_q : '0);
    word1 = b1_hit_q ? b1_fwd_q : (b1_vld_q ? b1_rd_q : '0);
    rdata_d = '0;
    if (op.mbox_rd) begin
      if (op.wide) begin
        rdata_d = {word1, word0};
      end else begin
        rdata_d = {{WordW{1'b0}}, (ofs_q[2] ? word1 : word0)};
      end
    end else if (op.st_rd) begin
      rdata_d = {{WordW{1'b0}}, status_q[core_idx]};
    end else if (op.en_rd) begin
      rdata_d = {{WordW{1'b0}}, enable_q[core_idx]};
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_acc) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q <= s_axis_tuser_i[0];
      core_q <= s_axis_tdata_i[3:0];
      ofs_q  <= s_axis_tdata_i[11:4];
      size_q <= s_axis_tdata_i[15:12];
      data_q <= s_axis_tdata_i[79:16];
    end
  end

  // mailbox banks: read launched with the request, write from the request ahead
  always_ff @(posedge clk_i) begin
    if (we0) begin
      bank0_mem[wrow0] <= wdat0;
    end
    if (we1) begin
      bank1_mem[wrow1] <= wdat1;
    end
    if (s_acc) begin
      b0_rd_q  <= bank0_mem[rd_row];
      b1_rd_q  <= bank1_mem[rd_row];
      b0_vld_q <= bank0_vld_q[rd_row];
      b1_vld_q <= bank1_vld_q[rd_row];
      b0_hit_q <= we0 && (wrow0 == rd_row);
      b1_hit_q <= we1 && (wrow1 == rd_row);
      b0_fwd_q <= wdat0;
      b1_fwd_q <= wdat1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank0_vld_q <= '0;
      bank1_vld_q <= '0;
    end else begin
      if (we0) begin
        bank0_vld_q[wrow0] <= 1'b1;
      end
      if (we1) begin
        bank1_vld_q[wrow1] <= 1'b1;
      end
    end
  end

  // status and enable registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        status_q[c] <= '0;
        enable_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CORES; c++) begin
        status_q[c] <= status_d[c];
        if (fire && op.en_wr && core_idx == CoreAW'(c)) begin
          enable_q[c] <= lo_w;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      err_q   <= op.err;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {irq_q, rdata_q};
  assign m_axis_tuser_o[0] = err_q;

endmodule

// ===== hw/rtl/ipimbx_checker.sv =====
`timescale 1ns / 1ps
// port-level checker of the ipi mailbox controller and its bind
module ipimbx_checker #(
  parameter int NUM_CORES = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [79:0] s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  localparam logic [15:0] IrqMask = 16'((32'd1 << NUM_CORES) - 32'd1);

  // no interrupt line beyond the populated cores
  a_irq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[79:64] & ~IrqMask) == 16'd0))
    else $error("irq line set for a missing core");

  // a refused request returns no data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[63:0] == 64'd0))
    else $error("read data on an access error");

  // a result after an empty pipe comes from an accepted request, by way of the request and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a matching request");

  // an empty result side never blocks requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request side stalled with empty result register");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind ipi_mailbox_controller_unit ipimbx_checker #(.NUM_CORES(NUM_CORES)) u_ipimbx_checker (.*);

// ===== tb/tb_ipi_mailbox_controller_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ipi mailbox controller with a shadow-state scoreboard
module tb_ipi_mailbox_controller_unit;
  import ipimbx_pkg::*;

  localparam int          NUM_CORES   = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          RAND_ITEMS  = 450;
  localparam int          LONG_STALL  = 300;

  // one bus request as it enters the block
  typedef struct {
    logic                  func;
    logic [CoreFieldW-1:0] core;
    logic [OfsW-1:0]       ofs;
    logic [SizeW-1:0]      size;
    logic [DataW-1:0]      data;
  } req_t;

  // one result as it leaves the block
  typedef struct {
    logic [DataW-1:0] read_data;
    logic [IrqW-1:0]  irq_lines;
    logic             access_error;
  } resp_t;

  // shadow copy of the register state; predicts the response of every accepted request
  class ipi_mailbox_shadow;
    logic [WordW-1:0] status_w [NUM_CORES];
    logic [WordW-1:0] enable_w [NUM_CORES];
    logic [WordW-1:0] mbox_w   [NUM_CORES * WordsPerCore];
    resp_t            awaited_resp [$];
    int unsigned      errors;

    function new();
      foreach (status_w[c]) status_w[c] = '0;
      foreach (enable_w[c]) enable_w[c] = '0;
      foreach (mbox_w[w]) mbox_w[w] = '0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_resp.size();
    endfunction

    // apply one accepted request to the shadow state and queue its response
    function void take_request(req_t r);
      resp_t            e;
      logic [DataW-1:0] d;
      int unsigned      idx;
      int unsigned      tgt;
      e.read_data    = '0;
      e.access_error = 1'b0;
      // a narrow access only carries the low word
      d = (r.size == Size4) ? {32'h0, r.data[31:0]} : r.data;
      if ((r.size != Size4 && r.size != Size8) || r.core >= NUM_CORES) begin
        e.access_error = 1'b1;
      end else if (r.ofs >= OfsMboxLo && r.ofs <= OfsMboxHi) begin
        if ((r.ofs & ({4'h0, r.size} - 8'd1)) != 8'h0) begin
          e.access_error = 1'b1;
        end else begin
          idx = int'(r.core) * WordsPerCore + int'((r.ofs - OfsMboxLo) >> 2);
          if (r.func == FuncWrite) begin
            mbox_w[idx] = d[31:0];
            if (r.size == Size8) mbox_w[idx + 1] = d[63:32];
          end else begin
            e.read_data[31:0] = mbox_w[idx];
            if (r.size == Size8) e.read_data[63:32] = mbox_w[idx + 1];
          end
        end
      end else if (r.func == FuncRead) begin
        if (r.ofs == OfsStatus) e.read_data = {32'h0, status_w[r.core]};
        else if (r.ofs == OfsEnable) e.read_data = {32'h0, enable_w[r.core]};
      end else begin
        tgt = int'(d[25:16]);
        case (r.ofs)
          OfsStatus, OfsSet: e.access_error = 1'b1;
          OfsEnable: enable_w[r.core] = d[31:0];
          OfsClear: status_w[r.core] &= ~d[31:0];
          OfsIpiSend: begin
            if (tgt >= NUM_CORES) e.access_error = 1'b1;
            else status_w[tgt] |= 32'h1 << d[4:0];
          end
          OfsMailSend: begin
            if (tgt >= NUM_CORES) e.access_error = 1'b1;
            else mbox_w[tgt * WordsPerCore + int'(d[4:2])] = d[63:32];
          end
          default: ;
        endcase
      end
      e.irq_lines = '0;
      for (int c = 0; c < NUM_CORES; c++) e.irq_lines[c] = |status_w[c];
      awaited_resp.push_back(e);
    endfunction

    // compare one response from the block with the oldest prediction
    function void check_response(resp_t a);
      resp_t e;
      if (awaited_resp.size() == 0) begin
        $display("%0t: response with none awaited, read_data %h irq_lines %h access_error %b",
                 $time, a.read_data, a.irq_lines, a.access_error);
        errors++;
        return;
      end
      e = awaited_resp.pop_front();
      if (a.read_data !== e.read_data) begin
        $display("%0t: read_data mismatch, expected %h, actual %h", $time, e.read_data,
                 a.read_data);
        errors++;
      end
      if (a.irq_lines !== e.irq_lines) begin
        $display("%0t: irq_lines mismatch, expected %h, actual %h", $time, e.irq_lines,
                 a.irq_lines);
        errors++;
      end
      if (a.access_error !== e.access_error) begin
        $display("%0t: access_error mismatch, expected %b, actual %b", $time,
                 e.access_error, a.access_error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  ipi_mailbox_controller_unit #(
    .NUM_CORES(NUM_CORES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  ipi_mailbox_shadow shadow = new();
  int unsigned       cycle_count = 0;
  // sender asks the receiver for one long hold-off
  bit                want_long_stall = 1'b0;
  // last part of the run: receiver stays ready
  bit                rx_steady = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    resp_t a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      a.read_data    = m_axis_tdata_o[63:0];
      a.irq_lines    = m_axis_tdata_o[79:64];
      a.access_error = m_axis_tuser_o[0];
      shadow.check_response(a);
    end
  end

  // result receiver: random ready bursts, one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      if (rx_steady) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else if (want_long_stall) begin
        want_long_stall = 1'b0;
        m_axis_tready_i <= 1'b0;
        n = 0;
        while (n < LONG_STALL) begin
          @(posedge clk_i);
          n++;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  function automatic req_t mk(logic func, int core, int ofs, int size, logic [63:0] data);
    req_t r;
    r.func = func;
    r.core = CoreFieldW'(core);
    r.ofs  = OfsW'(ofs);
    r.size = SizeW'(size);
    r.data = data;
    return r;
  endfunction

  // present one request and hold it until taken; the shadow notes it on acceptance
  task automatic send_request(req_t r);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.data, r.size, r.ofs, r.core};
    s_axis_tuser_i  <= r.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    shadow.take_request(r);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop offering until every predicted response is back
  task automatic wait_all_responses();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed accesses to mapped registers, some noise
  function automatic req_t random_request();
    req_t        r;
    logic [9:0]  tgt;
    int unsigned pick;
    r.func = FuncWrite;
    r.core = CoreFieldW'($urandom_range(0, NUM_CORES - 1));
    r.size = $urandom_range(0, 1) ? Size8 : Size4;
    r.data = {$urandom, $urandom};
    // targets mostly in range, now and then anywhere in the 10-bit field
    tgt = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(0, NUM_CORES - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.func = 1'($urandom_range(0, 1));
      r.core = CoreFieldW'($urandom_range(0, 15));
      r.ofs  = OfsW'($urandom_range(0, 255));
      r.size = SizeW'($urandom_range(1, 8));
    end else if (pick < 30) begin
      r.ofs         = OfsIpiSend;
      r.data[25:16] = tgt;
    end else if (pick < 42) begin
      r.ofs         = OfsMailSend;
      r.data[25:16] = tgt;
    end else if (pick < 52) begin
      // sparse masks so that status rarely empties at once
      r.ofs = OfsClear;
      if ($urandom_range(0, 1)) r.data[31:0] = 32'h1 << $urandom_range(0, 31);
      else r.data[31:0] = $urandom & $urandom & $urandom;
    end else if (pick < 60) begin
      r.func = 1'($urandom_range(0, 1));
      r.ofs  = OfsEnable;
    end else if (pick < 72) begin
      r.func = FuncRead;
      r.ofs  = OfsStatus;
    end else if (pick < 92) begin
      r.func = 1'($urandom_range(0, 1));
      r.ofs  = (r.size == Size8) ? OfsW'(OfsMboxLo + 8 * $urandom_range(0, 3))
                                 : OfsW'(OfsMboxLo + 4 * $urandom_range(0, 7));
    end else begin
      r.func = 1'($urandom_range(0, 1));
      r.ofs  = OfsW'(4 * $urandom_range(0, 19));
    end
    return r;
  endfunction

  initial begin : stimulus
    bit burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: register map corners and every refusal but a mail send to a missing core
    send_request(mk(FuncRead, 0, OfsStatus, 4, 64'h0));
    send_request(mk(FuncWrite, 0, OfsIpiSend, 4, 64'h0000_0000_0003_001f));
    send_request(mk(FuncWrite, 2, OfsIpiSend, 8, 64'hffff_ffff_fc00_ffe0));
    send_request(mk(FuncWrite, 0, OfsIpiSend, 4, 64'h0000_0000_0004_0005));
    send_request(mk(FuncWrite, 1, OfsIpiSend, 8, 64'h0000_0000_03ff_0001));
    send_request(mk(FuncWrite, 0, OfsStatus, 4, 64'h0000_0000_ffff_ffff));
    send_request(mk(FuncWrite, 1, OfsSet, 8, 64'h0000_0000_0000_0001));
    send_request(mk(FuncRead, 0, OfsSet, 4, 64'h0));
    send_request(mk(FuncWrite, 1, OfsEnable, 8, 64'hffff_ffff_ffff_ffff));
    send_request(mk(FuncRead, 1, OfsEnable, 8, 64'h0));
    send_request(mk(FuncWrite, 1, OfsMailSend, 8, 64'hdead_beef_0002_001c));
    send_request(mk(FuncWrite, 1, OfsMailSend, 4, 64'h1234_5678_0002_0018));
    send_request(mk(FuncRead, 2, 8'h38, 8, 64'h0));
    send_request(mk(FuncWrite, 3, OfsMboxLo, 8, 64'hffff_ffff_ffff_ffff));
    send_request(mk(FuncRead, 3, 8'h24, 4, 64'h0));
    send_request(mk(FuncRead, 0, 8'h24, 8, 64'h0));
    send_request(mk(FuncWrite, 0, 8'h22, 4, 64'h0000_0000_aaaa_5555));
    send_request(mk(FuncRead, 0, OfsStatus, 2, 64'h0));
    send_request(mk(FuncWrite, 0, OfsEnable, 1, 64'h0000_0000_0000_00ff));
    send_request(mk(FuncRead, 15, OfsStatus, 4, 64'h0));
    send_request(mk(FuncRead, 4, OfsEnable, 8, 64'h0));
    send_request(mk(FuncWrite, 3, OfsClear, 4, 64'hffff_ffff_8000_0000));
    send_request(mk(FuncRead, 3, OfsStatus, 8, 64'h0));
    send_request(mk(FuncRead, 0, 8'hff, 8, 64'h0));
    send_request(mk(FuncWrite, 0, 8'h10, 4, 64'h0123_4567_89ab_cdef));
    wait_all_responses();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // back-to-back burst into a long receiver hold-off fills the pipe
      if (i == 150) want_long_stall = 1'b1;
      burst = (i >= 150 && i < 210);
      if (i == 300) wait_all_responses();
      if (i == RAND_ITEMS - 80) rx_steady = 1'b1;
      if (!burst && i < RAND_ITEMS - 80 && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 17));
      send_request(random_request());
    end
    wait_all_responses();
    repeat (8) @(posedge clk_i);

    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
